// ===== design/wfd_pkg.sv =====
// shared types, constants and helpers for the websocket frame decoder
package wfd_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_CLOSED
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_EMPTY = 3'd1,
        KIND_PING  = 3'd2,
        KIND_PONG  = 3'd3,
        KIND_CLOSE = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] payload_byte;
        t_kind      kind;
        logic [3:0] frame_opcode;
        logic       frame_end;
    } t_result;

    function automatic logic is_control(input logic [3:0] opcode);
        return (opcode == OP_CLOSE) || (opcode == OP_PING) || (opcode == OP_PONG);
    endfunction

    function automatic t_kind event_kind(input logic [3:0] opcode);
        t_kind k;
        case (opcode)
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            OP_PONG:  k = KIND_PONG;
            default:  k = KIND_EMPTY;
        endcase
        return k;
    endfunction

endpackage

// ===== design/wfd_in_reg.sv =====
// input register stage for received bytes
module wfd_in_reg
    import wfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== design/wfd_parser.sv =====
// frame header parser, length tracking and payload unmasking
module wfd_parser
    import wfd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    t_phase                 r_phase,   n_phase;
    logic [3:0]             r_opcode,  n_opcode;
    logic                   r_mask,    n_mask;
    logic [3:0]             r_cnt,     n_cnt;
    logic [LENGTH_BITS-1:0] r_rem,     n_rem;
    logic [31:0]            r_key,     n_key;
    logic [1:0]             r_lane,    n_lane;

    logic       w_end;
    logic       w_data;
    logic       w_last;
    logic [7:0] w_key_byte;

    assign w_last     = (r_rem == LEN_ONE);
    assign w_key_byte = r_mask ? r_key[{~r_lane, 3'b000} +: 8] : 8'h00;

    // next state
    always_comb begin
        logic do_after;
        logic do_enter;
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_key    = r_key;
        n_lane   = r_lane;
        w_end    = 1'b0;
        w_data   = 1'b0;
        do_after = 1'b0;
        do_enter = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask = i_byte[7];
                    n_rem  = '0;
                    if (i_byte[6:0] == LEN7_EXT16) begin
                        n_phase = PH_EXTLEN;
                        n_cnt   = EXT16_BYTES;
                    end else if (i_byte[6:0] == LEN7_EXT64) begin
                        n_phase = PH_EXTLEN;
                        n_cnt   = EXT64_BYTES;
                    end else begin
                        n_rem    = LENGTH_BITS'(i_byte[6:0]);
                        do_after = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    if (r_rem[LENGTH_BITS-1 -: 8] != 8'h00) begin
                        n_rem = LEN_MAX;
                    end else begin
                        n_rem = {r_rem[LENGTH_BITS-9:0], i_byte};
                    end
                    n_cnt    = r_cnt - 4'd1;
                    do_after = (n_cnt == 4'd0);
                end
                PH_MASK: begin
                    n_key    = {r_key[23:0], i_byte};
                    n_cnt    = r_cnt - 4'd1;
                    do_enter = (n_cnt == 4'd0);
                end
                PH_PAYLOAD: begin
                    n_lane = r_lane + 2'd1;
                    n_rem  = r_rem - LEN_ONE;
                    if (is_control(r_opcode)) begin
                        w_end = w_last;
                    end else begin
                        w_data = 1'b1;
                        if (w_last) begin
                            n_phase = PH_HDR0;
                        end
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase
            if (do_after) begin
                n_key = '0;
                if (n_mask) begin
                    n_phase = PH_MASK;
                    n_cnt   = KEY_BYTES;
                end else begin
                    do_enter = 1'b1;
                end
            end
            if (do_enter) begin
                n_lane = 2'd0;
                if (n_rem == '0) begin
                    w_end = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            if (w_end) begin
                n_phase = (r_opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
            end
        end
    end

    // result
    always_comb begin
        o_res_valid        = w_end || w_data;
        o_res.frame_opcode = r_opcode;
        if (w_data) begin
            o_res.payload_byte = i_byte ^ w_key_byte;
            o_res.kind         = KIND_DATA;
            o_res.frame_end    = w_last;
        end else begin
            o_res.payload_byte = 8'h00;
            o_res.kind         = event_kind(r_opcode);
            o_res.frame_end    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_key    <= '0;
            r_lane   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_lane   <= n_lane;
        end
    end

`ifndef SYNTHESIS
    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |-> !o_res_valid)
        else $error("result produced after close");

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |=> (r_phase == PH_CLOSED))
        else $error("left closed phase without reset");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXTLEN || r_phase == PH_MASK) |-> (r_cnt != 4'd0))
        else $error("header byte count empty in header phase");

    a_event_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind != KIND_DATA) |->
            (o_res.frame_end && o_res.payload_byte == 8'h00))
        else $error("malformed event result");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != '0))
        else $error("payload phase with zero length left");
`endif

endmodule

// ===== design/wfd_out_reg.sv =====
// result register toward the output stream
module wfd_out_reg
    import wfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_step && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== design/websocket_frame_decoder_unit.sv =====
// top level of the websocket frame decoder
//
//   channel  | dir | handshake                     | payload
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata = rx_byte
//   m_axis   | out | m_axis_tvalid / m_axis_tready | tdata, tuser, tlast
//
// one byte per cycle sustained while m_axis is not stalled; a byte's result enters the result register
// after the byte is accepted and stepped through the parser (input register, then parser into result register)
// the per-byte parse and unmask step is a single shallow stage
// synchronous active-low reset returns to the first header byte, no clearing pass
// a stalled m_axis holds the result register and back-pressures s_axis
module websocket_frame_decoder_unit
    import wfd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [6:0] m_axis_tuser,   // [2:0] kind, [6:3] frame_opcode
    output logic       m_axis_tlast    // frame_end
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_take;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    assign w_step = w_in_valid && w_take;

    wfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    wfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_take      (w_take),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_out)
    );

    assign m_axis_tdata = w_out.payload_byte;
    assign m_axis_tuser = {w_out.frame_opcode, w_out.kind};
    assign m_axis_tlast = w_out.frame_end;

endmodule
